>>> rtl/fractal_value_noise_pixel_core_defines.svh
// assertion macros used by the fvn_back module of the noise pixel core
// no dependencies; fvn_back includes this file to check its own logic
`ifndef FRACTAL_VALUE_NOISE_PIXEL_CORE_DEFINES_SVH
`define FRACTAL_VALUE_NOISE_PIXEL_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication on the module clock
`define FVN_ASSERT_IMPL(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("assertion failed");
// next-cycle implication on the module clock
`define FVN_ASSERT_NEXT(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define FVN_ASSERT_IMPL(name, pre, post)
`define FVN_ASSERT_NEXT(name, pre, post)
`endif
`endif

>>> rtl/fvn_pkg.sv
// shared types, register codes and the cosine weight function for the noise core
// no dependencies
package fvn_pkg;

   // register indexes on the csr channel
   localparam logic [2:0] CSR_NOISE_SEED       = 3'd0;
   localparam logic [2:0] CSR_OCTAVE_COUNT     = 3'd1;
   localparam logic [2:0] CSR_ZOOM_SCALE       = 3'd2;
   localparam logic [2:0] CSR_PERSISTENCE_GAIN = 3'd3;
   localparam logic [2:0] CSR_RED_GAIN         = 3'd4;
   localparam logic [2:0] CSR_GREEN_GAIN       = 3'd5;
   localparam logic [2:0] CSR_BLUE_GAIN        = 3'd6;

   // pi in Q30
   localparam logic [63:0] PI_Q30 = 64'd3373259426;

   typedef struct packed {
      logic [31:0] noise_seed;
      logic [3:0]  octave_count;
      logic [15:0] zoom_scale;
      logic [15:0] persistence_gain;
      logic [15:0] red_gain;
      logic [15:0] green_gain;
      logic [15:0] blue_gain;
   } cfg_type;

   typedef struct packed {
      logic [9:0] col;
      logic [9:0] row;
   } pix_type;

   // squared sine of a Q30 angle, Taylor series to the 13th power, Q30 result
   function automatic logic [30:0] sine_sq_weight(input logic [63:0] ang);
      logic [63:0]        a2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic [63:0]        s;
      logic [63:0]        sq;
      a2   = (ang * ang) >> 30;
      term = ang;
      sum  = $signed(ang);
      term = ((term * a2) >> 30) / 64'd6;
      sum  = sum - $signed(term);
      term = ((term * a2) >> 30) / 64'd20;
      sum  = sum + $signed(term);
      term = ((term * a2) >> 30) / 64'd42;
      sum  = sum - $signed(term);
      term = ((term * a2) >> 30) / 64'd72;
      sum  = sum + $signed(term);
      term = ((term * a2) >> 30) / 64'd110;
      sum  = sum - $signed(term);
      term = ((term * a2) >> 30) / 64'd156;
      sum  = sum + $signed(term);
      if (sum < 0) sum = 64'sd0;
      if (sum > 64'sd1073741824) sum = 64'sd1073741824;
      s  = $unsigned(sum);
      sq = (s * s) >> 30;
      return sq[30:0];
   endfunction

endpackage

>>> rtl/fvn_front.sv
// front end: accepts pixel transactions, wraps coordinates to the frame, queues them
// depends on fvn_pkg
module fvn_front #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [23:0]      req_tdata,   // pixel_column [9:0], pixel_row [19:10], zero pad
   output logic             q_valid,
   output fvn_pkg::pix_type q_pix,
   input  logic             q_pop
);

   // reciprocals for the frame wrap, 20 fraction bits, rounded up
   localparam logic [31:0] RECIP_W = 32'(((64'd1 << 20) + MAX_WIDTH - 1) / MAX_WIDTH);
   localparam logic [31:0] RECIP_H = 32'(((64'd1 << 20) + MAX_HEIGHT - 1) / MAX_HEIGHT);

   // v mod modulus by reciprocal multiply and one correction
   function automatic logic [9:0] wrap(input logic [9:0] v, input logic [31:0] recip,
                                       input logic [31:0] modulus);
      logic [31:0] prod;
      logic [31:0] quot;
      logic [31:0] back;
      logic [31:0] rem;
      prod = {22'd0, v} * recip;
      quot = prod >> 20;
      back = quot * modulus;
      rem  = {22'd0, v} - back;
      if (back > {22'd0, v}) rem = rem + modulus;
      return rem[9:0];
   endfunction

   fvn_pkg::pix_type ent_ff [2];
   logic [1:0]       count_ff, count_in;
   logic             wr_ff, rd_ff;
   logic             push;
   fvn_pkg::pix_type pix;

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid & req_tready;
   assign q_valid    = (count_ff != 2'd0);
   assign q_pix      = ent_ff[rd_ff];

   // classify: wrap into the frame
   always_comb begin
      pix.col = wrap(req_tdata[9:0], RECIP_W, 32'(MAX_WIDTH));
      pix.row = wrap(req_tdata[19:10], RECIP_H, 32'(MAX_HEIGHT));
   end

   always_comb begin
      count_in = count_ff;
      if (push && !q_pop) count_in = count_ff + 2'd1;
      if (!push && q_pop) count_in = count_ff - 2'd1;
   end

   // two-entry queue
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) wr_ff <= ~wr_ff;
         if (q_pop) rd_ff <= ~rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push) ent_ff[wr_ff] <= pix;
   end

endmodule

>>> rtl/fvn_back.sv
// back end: octave sequencer with a shared multiplier, hashes, smoothing, blend, color
// depends on fvn_pkg and fractal_value_noise_pixel_core_defines.svh
`include "fractal_value_noise_pixel_core_defines.svh"
module fvn_back #(
   parameter int MAX_OCTAVES     = 8,
   parameter int COS_TABLE_DEPTH = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  fvn_pkg::cfg_type cfg,
   input  logic             q_valid,
   input  fvn_pkg::pix_type q_pix,
   output logic             q_pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [31:0]      rsp_tdata
);

   localparam int OW = $clog2(MAX_OCTAVES + 1);
   localparam int KW = $clog2(COS_TABLE_DEPTH);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DIV    = 4'd1;
   localparam logic [3:0] S_OCT    = 4'd2;
   localparam logic [3:0] S_HASH   = 4'd3;
   localparam logic [3:0] S_SMOOTH = 4'd4;
   localparam logic [3:0] S_LERP   = 4'd5;
   localparam logic [3:0] S_ACC    = 4'd6;
   localparam logic [3:0] S_CHAN   = 4'd7;
   localparam logic [3:0] S_OUT    = 4'd8;

   // cosine weight table, built at elaboration
   logic [30:0] wtab [COS_TABLE_DEPTH];
   for (genvar k = 0; k < COS_TABLE_DEPTH; k++) begin : g_wtab
      localparam logic [63:0] ANG = (fvn_pkg::PI_Q30 * k) / (2 * COS_TABLE_DEPTH);
      assign wtab[k] = fvn_pkg::sine_sq_weight(ANG);
   end

   // one long-division step: {quotient bit, remainder}
   function automatic logic [16:0] div_step(input logic [15:0] r, input logic b,
                                            input logic [15:0] z);
      logic [16:0] t;
      t = {r, b};
      if (t >= {1'b0, z}) return {1'b1, 16'(t - {1'b0, z})};
      return {1'b0, t[15:0]};
   endfunction

   logic [3:0]         state_ff;
   logic [2:0]         ph_ff;
   logic [5:0]         cnt_ff;
   logic [OW-1:0]      octs_ff, oct_ff;
   logic [15:0]        zoom_ff;
   logic [33:0]        divx_ff, divy_ff;
   logic [47:0]        qx_ff, qy_ff;
   logic [15:0]        rx_ff, ry_ff;
   logic signed [31:0] lat_ff [16];
   logic signed [31:0] sm_ff [4];
   logic signed [33:0] csum_ff [4];
   logic signed [33:0] ssum_ff [4];
   logic [30:0]        wx_ff, wy_ff;
   logic signed [31:0] top_ff, bot_ff, nz_ff;
   logic signed [19:0] total_ff;
   logic [31:0]        amp_ff;
   logic [31:0]        n_ff;
   logic signed [67:0] prod_ff;
   logic [7:0]         chan_ff [3];
   logic               rsp_valid_ff;
   logic [31:0]        rsp_data_ff;

   logic signed [33:0] mul_a, mul_b;
   logic signed [67:0] prod_in;
   logic [16:0]        stx, sty;
   logic [31:0]        hx, hy, n0, nmix, m32;
   logic signed [31:0] lerp_a, lerp_b, lerp_r;
   logic [30:0]        lerp_w;
   logic signed [21:0] acc_sum;
   logic [32:0]        amp_next;
   logic signed [20:0] t21;
   logic signed [29:0] t30;
   logic signed [12:0] v13;
   logic [15:0]        gain;
   logic [31:0]        kx_full, ky_full;
   logic [OW-1:0]      octs_in;
   logic               out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign q_pop      = (state_ff == S_IDLE) && q_valid;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // octave count clamp
   assign octs_in = ({1'b0, cfg.octave_count} > 5'(MAX_OCTAVES)) ? OW'(MAX_OCTAVES)
                                                                  : OW'(cfg.octave_count);

   // division steps, shared by the initial divide and the octave doubling
   always_comb begin
      if (state_ff == S_DIV) begin
         stx = div_step(rx_ff, divx_ff[33], zoom_ff);
         sty = div_step(ry_ff, divy_ff[33], zoom_ff);
      end else begin
         stx = div_step(rx_ff, 1'b0, zoom_ff);
         sty = div_step(ry_ff, 1'b0, zoom_ff);
      end
   end

   // lattice point and pre-mix for the current hash
   always_comb begin
      hx   = qx_ff[47:16] - 32'd1 + {30'd0, cnt_ff[1:0]};
      hy   = qy_ff[47:16] - 32'd1 + {30'd0, cnt_ff[3:2]};
      n0   = hx + hy * 32'd57 + cfg.noise_seed;
      nmix = (n0 << 13) ^ n0;
      m32  = prod_ff[31:0] + 32'd1376312589;
   end

   // blend operands, paired by phase
   always_comb begin
      case (ph_ff[2:1])
         2'd0: begin
            lerp_a = sm_ff[0];
            lerp_b = sm_ff[1];
            lerp_w = wx_ff;
         end
         2'd1: begin
            lerp_a = sm_ff[2];
            lerp_b = sm_ff[3];
            lerp_w = wx_ff;
         end
         default: begin
            lerp_a = top_ff;
            lerp_b = bot_ff;
            lerp_w = wy_ff;
         end
      endcase
      lerp_r = lerp_a + $signed(prod_ff[61:30]);
   end

   // accumulate, amplitude and color helpers
   always_comb begin
      acc_sum  = 22'(total_ff) + $signed(prod_ff[65:44]);
      amp_next = prod_ff[47:15];
      t21      = 21'(total_ff) + 21'sd65536;
      t30      = (30'(t21) <<< 8) - 30'(t21);
      v13      = $signed(prod_ff[44:32]);
      case (cnt_ff[1:0])
         2'd0:    gain = cfg.red_gain;
         2'd1:    gain = cfg.green_gain;
         default: gain = cfg.blue_gain;
      endcase
      kx_full = {16'd0, qx_ff[15:0]} * 32'(COS_TABLE_DEPTH);
      ky_full = {16'd0, qy_ff[15:0]} * 32'(COS_TABLE_DEPTH);
   end

   // shared multiplier operand select
   always_comb begin
      mul_a = 34'sd0;
      mul_b = 34'sd0;
      case (state_ff)
         S_HASH: begin
            case (ph_ff)
               3'd0: begin
                  mul_a = {2'b00, nmix};
                  mul_b = {2'b00, nmix};
               end
               3'd1: begin
                  mul_a = {2'b00, prod_ff[31:0]};
                  mul_b = 34'sd15731;
               end
               3'd2: begin
                  mul_a = {2'b00, n_ff};
                  mul_b = {2'b00, prod_ff[31:0] + 32'd789221};
               end
               default: ;
            endcase
         end
         S_LERP: begin
            mul_a = 34'(lerp_b) - 34'(lerp_a);
            mul_b = {3'b000, lerp_w};
         end
         S_ACC: begin
            if (ph_ff == 3'd0) begin
               mul_a = 34'(nz_ff);
               mul_b = {2'b00, amp_ff};
            end else begin
               mul_a = {2'b00, amp_ff};
               mul_b = {18'd0, cfg.persistence_gain};
            end
         end
         S_CHAN: begin
            mul_a = 34'(t30);
            mul_b = {18'd0, gain};
         end
         default: ;
      endcase
   end

   assign prod_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // smoothing lanes: corner and side sums, then the weighted combine
   for (genvar j = 0; j < 4; j++) begin : g_smooth
      localparam int CX = 1 + (j % 2);
      localparam int CY = 1 + (j / 2);
      logic signed [35:0] tot;
      assign tot = 36'(csum_ff[j]) + (36'(ssum_ff[j]) <<< 1)
                 + (36'(lat_ff[CY*4+CX]) <<< 2);
      always_ff @(posedge clock) begin
         if (state_ff == S_SMOOTH && ph_ff == 3'd0) begin
            csum_ff[j] <= 34'(lat_ff[(CY-1)*4+CX-1]) + 34'(lat_ff[(CY-1)*4+CX+1])
                        + 34'(lat_ff[(CY+1)*4+CX-1]) + 34'(lat_ff[(CY+1)*4+CX+1]);
            ssum_ff[j] <= 34'(lat_ff[CY*4+CX-1]) + 34'(lat_ff[CY*4+CX+1])
                        + 34'(lat_ff[(CY-1)*4+CX]) + 34'(lat_ff[(CY+1)*4+CX]);
         end
         if (state_ff == S_SMOOTH && ph_ff == 3'd1) sm_ff[j] <= tot[35:4];
      end
   end

   // control sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ph_ff        <= 3'd0;
         cnt_ff       <= 6'd0;
         oct_ff       <= '0;
         octs_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready && state_ff != S_OUT) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  octs_ff  <= octs_in;
                  oct_ff   <= '0;
                  cnt_ff   <= 6'd0;
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd33) begin
                  state_ff <= (octs_ff == '0) ? S_CHAN : S_OCT;
                  cnt_ff   <= 6'd0;
                  ph_ff    <= 3'd0;
               end
            end
            S_OCT: begin
               cnt_ff   <= 6'd0;
               ph_ff    <= 3'd0;
               state_ff <= S_HASH;
            end
            S_HASH: begin
               ph_ff <= ph_ff + 3'd1;
               if (ph_ff == 3'd3) begin
                  ph_ff  <= 3'd0;
                  cnt_ff <= cnt_ff + 6'd1;
                  if (cnt_ff[3:0] == 4'd15) begin
                     cnt_ff   <= 6'd0;
                     state_ff <= S_SMOOTH;
                  end
               end
            end
            S_SMOOTH: begin
               ph_ff <= ph_ff + 3'd1;
               if (ph_ff == 3'd1) begin
                  ph_ff    <= 3'd0;
                  state_ff <= S_LERP;
               end
            end
            S_LERP: begin
               ph_ff <= ph_ff + 3'd1;
               if (ph_ff == 3'd5) begin
                  ph_ff    <= 3'd0;
                  state_ff <= S_ACC;
               end
            end
            S_ACC: begin
               ph_ff <= ph_ff + 3'd1;
               if (ph_ff == 3'd3) begin
                  ph_ff  <= 3'd0;
                  oct_ff <= oct_ff + 1'b1;
                  if (oct_ff + 1'b1 == octs_ff) begin
                     cnt_ff   <= 6'd0;
                     state_ff <= S_CHAN;
                  end else begin
                     state_ff <= S_OCT;
                  end
               end
            end
            S_CHAN: begin
               ph_ff <= ph_ff + 3'd1;
               if (ph_ff == 3'd1) begin
                  ph_ff  <= 3'd0;
                  cnt_ff <= cnt_ff + 6'd1;
                  if (cnt_ff[1:0] == 2'd2) state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            divx_ff  <= {q_pix.col, 24'd0};
            divy_ff  <= {q_pix.row, 24'd0};
            zoom_ff  <= (cfg.zoom_scale == 16'd0) ? 16'd1 : cfg.zoom_scale;
            qx_ff    <= 48'd0;
            qy_ff    <= 48'd0;
            rx_ff    <= 16'd0;
            ry_ff    <= 16'd0;
            amp_ff   <= 32'd1073741824;
            total_ff <= 20'sd0;
         end
         S_DIV: begin
            qx_ff   <= {qx_ff[46:0], stx[16]};
            qy_ff   <= {qy_ff[46:0], sty[16]};
            rx_ff   <= stx[15:0];
            ry_ff   <= sty[15:0];
            divx_ff <= divx_ff << 1;
            divy_ff <= divy_ff << 1;
         end
         S_OCT: begin
            wx_ff <= wtab[kx_full[16+KW-1:16]];
            wy_ff <= wtab[ky_full[16+KW-1:16]];
         end
         S_HASH: begin
            if (ph_ff == 3'd0) n_ff <= nmix;
            if (ph_ff == 3'd3)
               lat_ff[cnt_ff[3:0]] <= 32'sd1073741824 - $signed({1'b0, m32[30:0]});
         end
         S_LERP: begin
            case (ph_ff)
               3'd1:    top_ff <= lerp_r;
               3'd3:    bot_ff <= lerp_r;
               3'd5:    nz_ff  <= lerp_r;
               default: ;
            endcase
         end
         S_ACC: begin
            if (ph_ff == 3'd1) begin
               if (acc_sum > 22'sd524287)       total_ff <= 20'sd524287;
               else if (acc_sum < -22'sd524288) total_ff <= -20'sd524288;
               else                             total_ff <= acc_sum[19:0];
            end
            if (ph_ff == 3'd3) begin
               amp_ff <= amp_next[32] ? 32'hFFFF_FFFF : amp_next[31:0];
               qx_ff  <= {qx_ff[46:0], stx[16]};
               qy_ff  <= {qy_ff[46:0], sty[16]};
               rx_ff  <= stx[15:0];
               ry_ff  <= sty[15:0];
            end
         end
         S_CHAN: begin
            if (ph_ff == 3'd1) begin
               if (v13 < 13'sd0)        chan_ff[cnt_ff[1:0]] <= 8'd0;
               else if (v13 > 13'sd255) chan_ff[cnt_ff[1:0]] <= 8'd255;
               else                     chan_ff[cnt_ff[1:0]] <= v13[7:0];
            end
         end
         S_OUT: begin
            if (out_free) rsp_data_ff <= {8'hFF, chan_ff[0], chan_ff[1], chan_ff[2]};
         end
         default: ;
      endcase
   end

   // checks
   `FVN_ASSERT_NEXT(a_out_wait, state_ff == S_OUT && rsp_valid_ff && !rsp_tready, state_ff == S_OUT)
   `FVN_ASSERT_IMPL(a_oct_range, state_ff != S_IDLE, oct_ff <= octs_ff)
   `FVN_ASSERT_IMPL(a_rem_range, state_ff == S_OCT || state_ff == S_HASH, rx_ff < zoom_ff && ry_ff < zoom_ff)
   `FVN_ASSERT_NEXT(a_pop_start, q_pop, state_ff == S_DIV)

endmodule

>>> rtl/fractal_value_noise_pixel_core.sv
// top level of the fractal value noise pixel core: csr registers, front and back ends
// depends on fvn_pkg, fvn_front and fvn_back
//
// Usage: send one pixel per req transaction (column and row, wrapped into the
// frame); one ARGB pixel comes back per rsp transaction, in order, alpha 0xFF.
// Registers are written on the csr channel (index, data); csr_ready is always
// high. The user must see that writes are made while no pixel is in flight;
// the block itself does not enforce this. Processing: the 34-step coordinate
// divide, then per octave sixteen lattice hashes of three multiplier passes
// each plus smoothing, blending and accumulation, then three color passes;
// hashes, blends, accumulation and color share one multiplier. A two-entry
// queue behind req lets the next pixels be taken while one is computed, and
// the result register lets the next pixel start while a finished one waits.
// Reset: synchronous, active high; registers return to their defaults, the
// queue empties and rsp_tvalid drops. When the receiver stalls, the result is
// held and the back end waits with the next finished pixel.
module fractal_value_noise_pixel_core #(
   parameter int MAX_OCTAVES     = 8,
   parameter int MAX_WIDTH       = 1024,
   parameter int MAX_HEIGHT      = 1024,
   parameter int COS_TABLE_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // pixel_column [9:0], pixel_row [19:10], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // argb_pixel [31:0]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   fvn_pkg::cfg_type cfg_ff;
   fvn_pkg::pix_type q_pix;
   logic             q_valid, q_pop;

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.noise_seed       <= 32'd0;
         cfg_ff.octave_count     <= 4'd1;
         cfg_ff.zoom_scale       <= 16'd256;
         cfg_ff.persistence_gain <= 16'd16384;
         cfg_ff.red_gain         <= 16'd32768;
         cfg_ff.green_gain       <= 16'd32768;
         cfg_ff.blue_gain        <= 16'd32768;
      end else if (csr_valid) begin
         case (csr_index)
            fvn_pkg::CSR_NOISE_SEED:       cfg_ff.noise_seed       <= csr_data;
            fvn_pkg::CSR_OCTAVE_COUNT:     cfg_ff.octave_count     <= csr_data[3:0];
            fvn_pkg::CSR_ZOOM_SCALE:       cfg_ff.zoom_scale       <= csr_data[15:0];
            fvn_pkg::CSR_PERSISTENCE_GAIN: cfg_ff.persistence_gain <= csr_data[15:0];
            fvn_pkg::CSR_RED_GAIN:         cfg_ff.red_gain         <= csr_data[15:0];
            fvn_pkg::CSR_GREEN_GAIN:       cfg_ff.green_gain       <= csr_data[15:0];
            fvn_pkg::CSR_BLUE_GAIN:        cfg_ff.blue_gain        <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   fvn_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_valid    (q_valid),
      .q_pix      (q_pix),
      .q_pop      (q_pop)
   );

   fvn_back #(
      .MAX_OCTAVES     (MAX_OCTAVES),
      .COS_TABLE_DEPTH (COS_TABLE_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_valid),
      .q_pix      (q_pix),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

>>> tb/sv/tb_fractal_value_noise_pixel_core.sv
// self-checking testbench for the fractal value noise pixel core
// depends on fvn_pkg and fractal_value_noise_pixel_core; predicts each pixel in fixed point
module tb_fractal_value_noise_pixel_core;

   localparam int MAX_OCT  = 8;
   localparam int COS_DEPTH = 256;
   localparam longint TOTAL_HI = 524287;
   localparam longint TOTAL_LO = -524288;
   localparam int LATENCY_WAIT = 800;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [31:0] csr_data;

   fractal_value_noise_pixel_core uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // register shadow used by the pixel predictor
   logic [31:0] seed_q  = 32'd0;
   logic [3:0]  octs_q  = 4'd1;
   logic [15:0] zoom_q  = 16'd256;
   logic [15:0] pers_q  = 16'd16384;
   logic [15:0] rgain_q = 16'd32768;
   logic [15:0] ggain_q = 16'd32768;
   logic [15:0] bgain_q = 16'd32768;

   function automatic longint fl_shr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint hash_value(logic [31:0] x, logic [31:0] y);
      logic [31:0] n;
      logic [31:0] m;
      n = x + y * 32'd57 + seed_q;
      n = (n << 13) ^ n;
      m = (n * (n * n * 32'd15731 + 32'd789221) + 32'd1376312589) & 32'h7fffffff;
      return 64'sd1073741824 - longint'({32'd0, m});
   endfunction

   function automatic longint smooth_value(logic [31:0] x, logic [31:0] y);
      longint c;
      longint s;
      c = hash_value(x - 1, y - 1) + hash_value(x + 1, y - 1)
        + hash_value(x - 1, y + 1) + hash_value(x + 1, y + 1);
      s = hash_value(x - 1, y) + hash_value(x + 1, y)
        + hash_value(x, y - 1) + hash_value(x, y + 1);
      return fl_shr(c + 2 * s + 4 * hash_value(x, y), 4);
   endfunction

   // squared sine weight from the top fraction bits, Taylor series
   function automatic longint blend_weight(logic [15:0] frac);
      logic [63:0] k;
      logic [63:0] a;
      logic [63:0] a2;
      logic [63:0] term;
      longint sum;
      logic [63:0] s;
      k = (64'(frac) * COS_DEPTH) >> 16;
      a = (64'd3373259426 * k) / (2 * COS_DEPTH);
      a2 = (a * a) >> 30;
      term = a;
      sum = longint'(a);
      for (int n = 1; n <= 6; n++) begin
         term = (term * a2) >> 30;
         term = term / 64'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) sum = sum - longint'(term);
         else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      if (sum > 1073741824) sum = 1073741824;
      s = 64'(sum);
      return longint'((s * s) >> 30);
   endfunction

   function automatic longint blend(longint a, longint b, longint w);
      return a + fl_shr((b - a) * w, 30);
   endfunction

   function automatic longint octave_value(logic [63:0] cx, logic [63:0] cy);
      logic [31:0] ix;
      logic [31:0] iy;
      longint wx;
      longint wy;
      longint top;
      longint bot;
      ix = cx[47:16];
      iy = cy[47:16];
      wx = blend_weight(cx[15:0]);
      wy = blend_weight(cy[15:0]);
      top = blend(smooth_value(ix, iy), smooth_value(ix + 1, iy), wx);
      bot = blend(smooth_value(ix, iy + 1), smooth_value(ix + 1, iy + 1), wx);
      return blend(top, bot, wy);
   endfunction

   function automatic logic [7:0] color_byte(longint total, logic [15:0] gain);
      longint v;
      v = fl_shr((total + 65536) * 255 * longint'({48'd0, gain}), 32);
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return v[7:0];
   endfunction

   function automatic logic [31:0] predict_pixel(logic [9:0] col, logic [9:0] row);
      logic [63:0] zoom;
      int          octs;
      logic [63:0] amp;
      longint      total;
      logic [63:0] cx;
      logic [63:0] cy;
      zoom = (zoom_q == 0) ? 64'd1 : 64'(zoom_q);
      octs = (octs_q > MAX_OCT) ? MAX_OCT : int'(octs_q);
      amp = 64'd1073741824;
      total = 0;
      for (int i = 0; i < octs; i++) begin
         cx = (64'(col) << (24 + i)) / zoom;
         cy = (64'(row) << (24 + i)) / zoom;
         total = total + fl_shr(octave_value(cx, cy) * longint'(amp), 44);
         if (total > TOTAL_HI) total = TOTAL_HI;
         if (total < TOTAL_LO) total = TOTAL_LO;
         amp = (amp * 64'(pers_q)) >> 15;
         if (amp > 64'hFFFFFFFF) amp = 64'hFFFFFFFF;
      end
      return {8'hFF, color_byte(total, rgain_q), color_byte(total, ggain_q),
              color_byte(total, bgain_q)};
   endfunction

   // expected pixel store and comparison
   class pixel_scoreboard;
      logic [31:0] pending[$];
      int          errors = 0;
      int          checked = 0;

      function void note_pixel(logic [31:0] argb);
         pending.push_back(argb);
      endfunction

      function void check_pixel(logic [31:0] argb);
         logic [31:0] want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected pixel, expected none, actual %h", $realtime, argb);
            errors++;
            return;
         end
         want = pending.pop_front();
         checked++;
         if (want !== argb) begin
            $display("%0t: argb_pixel mismatch, expected %h, actual %h",
                     $realtime, want, argb);
            errors++;
         end
      endfunction
   endclass

   pixel_scoreboard sb;
   int sent_pixels = 0;
   int cfg_phases = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #100000000;
      $display("Verification failed");
      $finish;
   end

   // output side: random stall, sample at rising edge
   initial begin
      int stall;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         stall = $urandom_range(0, 4);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!(rsp_tvalid && rsp_tready)) @(posedge clock);
         sb.check_pixel(rsp_tdata);
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      case (idx)
         fvn_pkg::CSR_NOISE_SEED:       seed_q  = val;
         fvn_pkg::CSR_OCTAVE_COUNT:     octs_q  = val[3:0];
         fvn_pkg::CSR_ZOOM_SCALE:       zoom_q  = val[15:0];
         fvn_pkg::CSR_PERSISTENCE_GAIN: pers_q  = val[15:0];
         fvn_pkg::CSR_RED_GAIN:         rgain_q = val[15:0];
         fvn_pkg::CSR_GREEN_GAIN:       ggain_q = val[15:0];
         default:                       bgain_q = val[15:0];
      endcase
   endtask

   // one pixel transaction with a random leading gap
   task automatic send_pixel(logic [9:0] col, logic [9:0] row);
      @(negedge clock);
      repeat ($urandom_range(0, 4)) @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {4'd0, row, col};
      sb.note_pixel(predict_pixel(col, row));
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      req_tvalid <= 1'b0;
      sent_pixels++;
   endtask

   task automatic drain_all();
      int guard;
      guard = 0;
      while (sb.pending.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      if (sb.pending.size() != 0) begin
         $display("Verification failed");
         $finish;
      end
      repeat (LATENCY_WAIT) @(posedge clock);
   endtask

   function automatic logic [15:0] rand_gain();
      case ($urandom_range(0, 3))
         0: return 16'd0;
         1: return 16'd32768;
         default: return 16'($urandom_range(0, 32768));
      endcase
   endfunction

   initial begin
      logic [9:0] col;
      logic [9:0] row;
      sb = new();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_index = fvn_pkg::CSR_NOISE_SEED;
      csr_data = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: reset defaults, field extremes
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd1023, 10'd1023);
      send_pixel(10'd0, 10'd1023);
      send_pixel(10'd1023, 10'd0);
      send_pixel(10'h155, 10'h2AA);
      send_pixel(10'h2AA, 10'h155);
      drain_all();

      // directed: zero zoom, too many octaves, extreme seed and gains
      write_reg(fvn_pkg::CSR_ZOOM_SCALE, 32'd0);
      write_reg(fvn_pkg::CSR_OCTAVE_COUNT, 32'd15);
      write_reg(fvn_pkg::CSR_NOISE_SEED, 32'h80000000);
      write_reg(fvn_pkg::CSR_PERSISTENCE_GAIN, 32'd32768);
      write_reg(fvn_pkg::CSR_RED_GAIN, 32'd0);
      write_reg(fvn_pkg::CSR_GREEN_GAIN, 32'd32768);
      write_reg(fvn_pkg::CSR_BLUE_GAIN, 32'd1);
      send_pixel(10'd1023, 10'd1023);
      send_pixel(10'd7, 10'd3);
      drain_all();

      // directed: max zoom, zero octaves, zero persistence
      write_reg(fvn_pkg::CSR_ZOOM_SCALE, 32'd65535);
      write_reg(fvn_pkg::CSR_OCTAVE_COUNT, 32'd0);
      write_reg(fvn_pkg::CSR_NOISE_SEED, 32'h7fffffff);
      send_pixel(10'd500, 10'd600);
      drain_all();
      write_reg(fvn_pkg::CSR_OCTAVE_COUNT, 32'd8);
      write_reg(fvn_pkg::CSR_PERSISTENCE_GAIN, 32'd0);
      write_reg(fvn_pkg::CSR_ZOOM_SCALE, 32'd1);
      send_pixel(10'd1, 10'd1);
      send_pixel(10'd1022, 10'd513);
      drain_all();

      // random phases with a fresh register setting each time
      for (int p = 0; p < 19; p++) begin
         write_reg(fvn_pkg::CSR_NOISE_SEED, $urandom());
         write_reg(fvn_pkg::CSR_OCTAVE_COUNT, (p % 5 == 0) ? $urandom_range(0, 15)
                                                           : $urandom_range(1, 3));
         write_reg(fvn_pkg::CSR_ZOOM_SCALE,
                   ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
                                               : $urandom_range(64, 4096));
         write_reg(fvn_pkg::CSR_PERSISTENCE_GAIN,
                   ($urandom_range(0, 5) == 0) ? 32'd32768 : $urandom_range(0, 32768));
         write_reg(fvn_pkg::CSR_RED_GAIN, rand_gain());
         write_reg(fvn_pkg::CSR_GREEN_GAIN, rand_gain());
         write_reg(fvn_pkg::CSR_BLUE_GAIN, rand_gain());
         cfg_phases++;
         for (int i = 0; i < 100; i++) begin
            col = 10'($urandom_range(0, 1023));
            row = 10'($urandom_range(0, 1023));
            send_pixel(col, row);
         end
         drain_all();
      end

      $display("covered %0d pixels and %0d checked results over %0d random register phases",
               sent_pixels, sb.checked, cfg_phases);
      if (sb.errors == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end
endmodule
